@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/msvf_pkg.sv @@
// Package: types, constants and arithmetic helpers of the state variable filter
package msvf_pkg;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COEF_BITS_DEF    = 24;

    localparam int WORK_BITS = 32;
    localparam int NUM_REGS  = 7;
    localparam int IDX_BITS  = 3;

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_A1 = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_A2 = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_A3 = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_K  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_WL = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_WB = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_WH = 3'd6;

    // Fixed payload widths of the default build
    typedef struct packed {
        logic signed [23:0] sample_in;
        logic               chan;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               out_chan;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_OUT
    } state_t;

    // Saturate a 36-bit signed sum to 32 bits
    function automatic logic signed [WORK_BITS-1:0] sat36(input logic signed [35:0] v);
        logic signed [WORK_BITS-1:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[WORK_BITS-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/msvf_serial_mul.sv @@
// Bit-serial multiplier: unsigned coefficient times signed 32-bit value, rounded
module msvf_serial_mul #(
    parameter int COEF_BITS = msvf_pkg::COEF_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [COEF_BITS-1:0]        coef,
    input  logic signed [31:0]          val,
    output logic                        done,
    output logic signed [35:0]          prod
);
    localparam int CFRAC  = COEF_BITS - 2;
    localparam int ACC_W  = 32 + COEF_BITS + 1;
    localparam int CNT_W  = $clog2(COEF_BITS + 1);

    logic [COEF_BITS-1:0]     coef_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  addend_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [ACC_W-1:0]  rnd;

    // One coefficient bit per cycle, LSB first, shifted addend
    // done rises together with the last partial sum landing in the accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            done_reg <= (cnt_reg == CNT_W'(COEF_BITS - 1));
            if (cnt_reg == CNT_W'(COEF_BITS - 1))
                busy_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            coef_reg   <= coef;
            acc_reg    <= ACC_W'(signed'(1) <<< (CFRAC - 1));
            addend_reg <= ACC_W'(val);
        end
        else if (busy_reg)
        begin
            if (coef_reg[0])
                acc_reg <= acc_reg + addend_reg;
            coef_reg   <= coef_reg >> 1;
            addend_reg <= addend_reg <<< 1;
        end
    end

    assign done = done_reg;
    assign rnd  = acc_reg >>> CFRAC;
    assign prod = rnd[35:0];
endmodule

@@ rtl/core/morphing_state_variable_filter_unit.sv @@
// Two-channel trapezoidal state variable filter with one shared bit-serial multiplier.
// Each request runs eight products through the serial multiplier; each product starts
// from a load step and waits in the multiply state until done. One request is in flight
// at a time; the result register holds until taken while the next request may be
// accepted only after that.
module morphing_state_variable_filter_unit #(
    parameter int NUM_CHANNELS = msvf_pkg::NUM_CHANNELS_DEF,
    parameter int COEF_BITS    = msvf_pkg::COEF_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  msvf_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output msvf_pkg::out_item_t       out_data,
    input  logic                      cfg_we,
    input  logic [msvf_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SHIFT = 25 - msvf_pkg::SAMPLE_BITS_DEF;

    logic [COEF_BITS-1:0] a1_reg, a2_reg, a3_reg, k_reg;
    logic [COEF_BITS-2:0] wl_reg, wb_reg, wh_reg;

    logic signed [31:0] i1_reg [NUM_CHANNELS];
    logic signed [31:0] i2_reg [NUM_CHANNELS];

    msvf_pkg::state_t state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic [CH_W-1:0] ch_reg;
    logic            chbit_reg;
    logic signed [31:0] x_reg, v3_reg, v1_reg, v2_reg, bp_reg, hp_reg, i1c_reg, i2c_reg;
    logic signed [35:0] t_reg, acc_reg;
    logic signed [23:0] y_reg;

    logic mstart, mdone;
    logic [COEF_BITS-1:0] mcoef;
    logic signed [31:0] mval;
    logic signed [35:0] mprod;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= COEF_BITS'(187310);
            a2_reg <= COEF_BITS'(699051);
            a3_reg <= COEF_BITS'(2608891);
            k_reg  <= COEF_BITS'(8388608);
            wl_reg <= (COEF_BITS-1)'(4194304);
            wb_reg <= '0;
            wh_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msvf_pkg::REG_A1: a1_reg <= cfg_data;
                msvf_pkg::REG_A2: a2_reg <= cfg_data;
                msvf_pkg::REG_A3: a3_reg <= cfg_data;
                msvf_pkg::REG_K:  k_reg  <= cfg_data;
                msvf_pkg::REG_WL: wl_reg <= cfg_data[COEF_BITS-2:0];
                msvf_pkg::REG_WB: wb_reg <= cfg_data[COEF_BITS-2:0];
                msvf_pkg::REG_WH: wh_reg <= cfg_data[COEF_BITS-2:0];
                default: ;
            endcase
        end
    end

    // Operand select for the current product
    always_comb
    begin
        mcoef = '0;
        mval  = '0;
        case (op_reg)
            4'd0: begin mcoef = a1_reg; mval = i1c_reg; end
            4'd1: begin mcoef = a2_reg; mval = v3_reg;  end
            4'd2: begin mcoef = a2_reg; mval = i1c_reg; end
            4'd3: begin mcoef = a3_reg; mval = v3_reg;  end
            4'd4: begin mcoef = k_reg;  mval = v1_reg;  end
            4'd5: begin mcoef = COEF_BITS'(wl_reg); mval = v2_reg; end
            4'd6: begin mcoef = COEF_BITS'(wb_reg); mval = bp_reg; end
            4'd7: begin mcoef = COEF_BITS'(wh_reg); mval = hp_reg; end
            default: ;
        endcase
    end

    msvf_serial_mul #(.COEF_BITS(COEF_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .coef  (mcoef),
        .val   (mval),
        .done  (mdone),
        .prod  (mprod)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        mstart     = 1'b0;
        unique case (state_reg)
            msvf_pkg::ST_IDLE:
                if (in_valid) state_next = msvf_pkg::ST_STEP;
            msvf_pkg::ST_STEP:
            begin
                mstart = 1'b1;
                state_next = msvf_pkg::ST_MUL;
            end
            msvf_pkg::ST_MUL:
                if (mdone)
                begin
                    op_next = op_reg + 4'd1;
                    state_next = (op_reg == 4'd7) ? msvf_pkg::ST_OUT : msvf_pkg::ST_STEP;
                end
            msvf_pkg::ST_OUT:
                if (out_ready) state_next = msvf_pkg::ST_IDLE;
            default: state_next = msvf_pkg::ST_IDLE;
        endcase
        if (state_reg == msvf_pkg::ST_IDLE) op_next = 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msvf_pkg::ST_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready  = (state_reg == msvf_pkg::ST_IDLE);
    assign out_valid = (state_reg == msvf_pkg::ST_OUT);
    assign out_data.sample_out = y_reg;
    assign out_data.out_chan   = chbit_reg;

    // Intermediate sums with saturation
    logic signed [35:0] s_sum, s_v3, s_2v1, s_2v2, s_hp, s_out, y_round;
    logic [CH_W-1:0] in_ch;
    logic signed [31:0] x_in;
    // one-bit channel field: a single channel folds everything onto entry zero
    assign in_ch = (NUM_CHANNELS > 1) ? CH_W'(in_data.chan) : '0;
    assign x_in  = msvf_pkg::sat36(36'(in_data.sample_in) <<< SHIFT);
    assign s_v3  = 36'(x_in) - 36'(i2_reg[in_ch]);
    assign s_sum = t_reg + mprod;
    assign s_2v1 = (36'(msvf_pkg::sat36(s_sum)) <<< 1) - 36'(i1c_reg);
    assign s_2v2 = (36'(msvf_pkg::sat36(s_sum)) <<< 1) - 36'(i2c_reg);
    assign s_hp  = 36'(x_reg) - 36'(msvf_pkg::sat36(mprod)) - 36'(v2_reg);
    assign s_out = acc_reg + mprod;
    assign y_round = (s_out + 36'sd1) >>> SHIFT;

    // Datapath registers and integrator update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                i1_reg[c] <= '0;
                i2_reg[c] <= '0;
            end
        end
        else if (state_reg == msvf_pkg::ST_MUL && mdone)
        begin
            if (op_reg == 4'd1) i1_reg[ch_reg] <= msvf_pkg::sat36(s_2v1);
            if (op_reg == 4'd3) i2_reg[ch_reg] <= msvf_pkg::sat36(s_2v2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == msvf_pkg::ST_IDLE && in_valid)
        begin
            ch_reg    <= in_ch;
            chbit_reg <= in_data.chan;
            x_reg     <= x_in;
            v3_reg    <= msvf_pkg::sat36(s_v3);
            i1c_reg   <= i1_reg[in_ch];
            i2c_reg   <= i2_reg[in_ch];
        end
        else if (state_reg == msvf_pkg::ST_MUL && mdone)
        begin
            case (op_reg)
                4'd0: t_reg <= mprod;
                4'd1: begin v1_reg <= msvf_pkg::sat36(s_sum); t_reg <= 36'(i2c_reg); end
                4'd2: t_reg <= t_reg + mprod;
                4'd3: v2_reg <= msvf_pkg::sat36(s_sum);
                4'd4: begin bp_reg <= msvf_pkg::sat36(mprod);
                            hp_reg <= msvf_pkg::sat36(s_hp); end
                4'd5: acc_reg <= mprod;
                4'd6: acc_reg <= s_out;
                4'd7:
                begin
                    if (y_round > 36'sd8388607)       y_reg <= 24'sh7fffff;
                    else if (y_round < -36'sd8388608) y_reg <= 24'sh800000;
                    else                               y_reg <= y_round[23:0];
                end
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/core/msvf_checker.sv @@
// Port-level checker for the filter unit and its bind
`include "assert_macros.svh"
module msvf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input msvf_pkg::out_item_t out_data
);
    `CHK_ALWAYS(a_excl, clk, rst_n, !(in_ready && out_valid), "ready while result pending")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
    `CHK_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken while busy")
endmodule

bind morphing_state_variable_filter_unit msvf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
